[design/hkt_pkg.sv]
// ----------------------------------------------------------------------------
// hkt_pkg
// Shared types and constants for the linear-probe key table: field widths,
// operation codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hkt_pkg;

   localparam int KEY_W   = 31;
   localparam int FUNC_W  = 2;
   localparam int FILL_W  = 10;
   localparam int OUT_W   = 10;
   localparam int COUNT_W = 11;

   localparam logic [FILL_W-1:0] FILL_RESET = 10'd768;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // mixing constants, one per round
   localparam logic [31:0] MIX_C0 = 32'h7ed55d16;
   localparam logic [31:0] MIX_C1 = 32'hc761c23c;
   localparam logic [31:0] MIX_C2 = 32'h165667b1;
   localparam logic [31:0] MIX_C3 = 32'hd3a2646c;
   localparam logic [31:0] MIX_C4 = 32'hfd7046c5;
   localparam logic [31:0] MIX_C5 = 32'hb55a4f09;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_HASH,
      ST_REDUCE,
      ST_PROBE,
      ST_CLEAR,
      ST_FINISH
   } hkt_state_type;

   typedef struct packed {
      logic accept;         // capture request, start hash
      logic hash_step;      // run one pair of mix rounds
      logic reduce_step;    // run one step of the slot reduction
      logic load_home;      // start probing at the home slot
      logic probe_advance;  // step to the next slot
      logic probe_stop;     // capture probe outcome
      logic sweep_start;    // point at slot 0, zero the count
      logic sweep_write;    // empty the current slot
      logic sweep_advance;  // step the sweep
      logic finish;         // commit and load the response register
   } hkt_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              hash_last;
      logic              reduce_done;
      logic              probe_hit;
      logic              probe_empty;
      logic              probe_last;
      logic              sweep_last;
   } hkt_status_type;

endpackage

[design/hkt_hash.sv]
// ----------------------------------------------------------------------------
// hkt_hash
// Six-round 32-bit key mix, two rounds per cycle, followed by reduction of
// the mixed value to a home slot (mask, or a reciprocal multiply, remainder
// and correction when the slot count is not a power of two).
// ----------------------------------------------------------------------------
module hkt_hash
   import hkt_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [KEY_W-1:0]           key,
   input  logic                       step,
   input  logic                       reduce_step,
   output logic                       hash_last,
   output logic                       reduce_done,
   output logic [$clog2(SLOTS)-1:0]   home
);

   localparam int IDX_W = $clog2(SLOTS);

   function automatic logic [31:0] mix_pair(input logic [31:0] v, input logic [1:0] p);
      logic [31:0] x;
      x = v;
      case (p)
         2'd0: begin
            x = (x + MIX_C0) + (x << 12);
            x = (x ^ MIX_C1) ^ (x >> 19);
         end
         2'd1: begin
            x = (x + MIX_C2) + (x << 5);
            x = (x + MIX_C3) ^ (x << 9);
         end
         default: begin
            x = (x + MIX_C4) + (x << 3);
            x = (x ^ MIX_C5) ^ (x >> 16);
         end
      endcase
      return x;
   endfunction

   logic [31:0] x_ff, x_in;
   logic [1:0]  pair_ff, pair_in;

   assign hash_last = (pair_ff == 2'd2);

   always_comb begin
      x_in    = x_ff;
      pair_in = pair_ff;
      if (load) begin
         x_in    = {1'b0, key};
         pair_in = 2'd0;
      end else if (step) begin
         x_in    = mix_pair(x_ff, pair_ff);
         pair_in = hash_last ? pair_ff : pair_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (reset) begin
         pair_ff <= 2'd0;
      end else begin
         pair_ff <= pair_in;
      end
   end

   if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
      assign reduce_done = 1'b1;
      assign home        = x_ff[IDX_W-1:0];
   end else begin : g_recip
      // the truncated reciprocal gives a quotient at most one low, so one
      // compare and subtract finishes the remainder
      localparam logic [31:0]    RECIP   = 32'((64'd1 << 32) / 64'(SLOTS));
      localparam logic [IDX_W:0] MODULUS = (IDX_W+1)'(SLOTS);

      logic [63:0]    prod_ff, prod_in;
      logic [IDX_W:0] rem_ff, rem_in;
      logic [1:0]     phase_ff, phase_in;
      logic [31:0]    qd;
      logic [31:0]    rem_full;
      logic [IDX_W:0] rem_fix;

      assign qd       = prod_ff[63:32] * 32'(SLOTS);
      assign rem_full = x_ff - qd;
      assign rem_fix  = (rem_ff >= MODULUS) ? rem_ff - MODULUS : rem_ff;

      always_comb begin
         prod_in  = prod_ff;
         rem_in   = rem_ff;
         phase_in = phase_ff;
         if (load || step) begin
            phase_in = 2'd0;
         end else if (reduce_step && (phase_ff != 2'd2)) begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd0) begin
               prod_in = 64'(x_ff) * 64'(RECIP);
            end else begin
               rem_in = rem_full[IDX_W:0];
            end
         end
      end

      assign reduce_done = (phase_ff == 2'd2);
      assign home        = rem_fix[IDX_W-1:0];

      always_ff @(posedge clock) begin
         prod_ff <= prod_in;
         rem_ff  <= rem_in;
         if (reset) begin
            phase_ff <= 2'd0;
         end else begin
            phase_ff <= phase_in;
         end
      end
   end

endmodule

[design/hkt_datapath.sv]
// ----------------------------------------------------------------------------
// hkt_datapath
// Slot memory ({valid, key} per slot), probe pointer and counter, entry count,
// fill limit register and the response register.
// ----------------------------------------------------------------------------
module hkt_datapath
   import hkt_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cfg_we,
   input  logic [FILL_W-1:0]   cfg_data,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [KEY_W-1:0]    req_lookup_key,
   input  hkt_cmd_type         cmd,
   output hkt_status_type      status,
   output logic                rsp_hit,
   output logic                rsp_inserted,
   output logic [OUT_W-1:0]    rsp_slot,
   output logic                rsp_status,
   output logic [OUT_W-1:0]    rsp_occupancy
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

   logic [KEY_W:0]      mem [SLOTS];
   logic [KEY_W:0]      rdata_ff;

   logic [KEY_W-1:0]    key_ff;
   logic [FUNC_W-1:0]   func_ff;
   logic [IDX_W-1:0]    pos_ff, pos_in, pos_next;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [FILL_W-1:0]   max_fill_ff;
   logic                found_ff, empty_ff;

   logic                hash_last, reduce_done;
   logic [IDX_W-1:0]    home;

   logic                entry_valid, room, do_insert, is_lookup;
   logic                mem_we;
   logic [KEY_W:0]      mem_wdata;

   logic                hit_ff, inserted_ff, status_ff;
   logic [OUT_W-1:0]    slot_ff, occ_ff;

   hkt_hash #(
      .SLOTS (SLOTS)
   ) u_hash (
      .clock       (clock),
      .reset       (reset),
      .load        (cmd.accept),
      .key         (req_lookup_key),
      .step        (cmd.hash_step),
      .reduce_step (cmd.reduce_step),
      .hash_last   (hash_last),
      .reduce_done (reduce_done),
      .home        (home)
   );

   assign entry_valid = rdata_ff[KEY_W];
   assign pos_next    = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;

   assign status.func        = func_ff;
   assign status.hash_last   = hash_last;
   assign status.reduce_done = reduce_done;
   assign status.probe_hit   = entry_valid && (rdata_ff[KEY_W-1:0] == key_ff);
   assign status.probe_empty = !entry_valid;
   assign status.probe_last  = (cnt_ff == LAST_SLOT);
   assign status.sweep_last  = (pos_ff == LAST_SLOT);

   assign is_lookup = (func_ff == FUNC_FIND) || (func_ff == FUNC_GET);
   assign room      = count_ff < {1'b0, max_fill_ff};
   assign do_insert = (func_ff == FUNC_GET) && !found_ff && empty_ff && room;

   always_comb begin
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (cmd.load_home) begin
         pos_in = home;
         cnt_in = '0;
      end else if (cmd.probe_advance) begin
         pos_in = pos_next;
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.sweep_advance) begin
         pos_in = pos_next;
      end else if (cmd.sweep_start) begin
         pos_in = '0;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.sweep_start) begin
         count_in = '0;
      end else if (cmd.finish && do_insert) begin
         count_in = count_ff + 1'b1;
      end
   end

   assign mem_we    = cmd.sweep_write || (cmd.finish && do_insert);
   assign mem_wdata = cmd.sweep_write ? '0 : {1'b1, key_ff};

   // read follows pos_in, so rdata_ff tracks pos_ff (read before write)
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pos_ff] <= mem_wdata;
      end
      rdata_ff <= mem[pos_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         cnt_ff      <= '0;
         count_ff    <= '0;
         max_fill_ff <= FILL_RESET;
      end else begin
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         count_ff <= count_in;
         if (cfg_we) begin
            max_fill_ff <= cfg_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff  <= req_lookup_key;
         func_ff <= req_func;
      end
      if (cmd.probe_stop) begin
         found_ff <= status.probe_hit;
         empty_ff <= status.probe_empty;
      end
      if (cmd.finish) begin
         hit_ff      <= is_lookup && found_ff;
         inserted_ff <= do_insert;
         slot_ff     <= (is_lookup && found_ff) || do_insert ? OUT_W'(pos_ff) : '0;
         status_ff   <= (func_ff == FUNC_GET) && !found_ff && !do_insert;
         occ_ff      <= count_in[OUT_W-1:0];
      end
   end

   assign rsp_hit       = hit_ff;
   assign rsp_inserted  = inserted_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

endmodule

[design/hkt_ctrl.sv]
// ----------------------------------------------------------------------------
// hkt_ctrl
// Sequencer for the key table: reset sweep, hash, reduction, probing, clear
// sweep and handoff to the response register.
// ----------------------------------------------------------------------------
module hkt_ctrl
   import hkt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  hkt_status_type  status,
   output hkt_cmd_type     cmd
);

   hkt_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.sweep_advance = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_func) inside
                  FUNC_FIND, FUNC_GET: state_in = ST_HASH;
                  FUNC_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (status.hash_last) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
            if (status.reduce_done) begin
               cmd.load_home = 1'b1;
               state_in      = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.probe_hit || status.probe_empty || status.probe_last) begin
               cmd.probe_stop = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               cmd.probe_advance = 1'b1;
            end
         end
         ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.sweep_advance = 1'b1;
            end
         end
         ST_FINISH: begin
            // hold until the response register can take the result
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

[design/hashed_key_table_linear_probe_core.sv]
// ----------------------------------------------------------------------------
// hashed_key_table_linear_probe_core
// Open-addressing key table with linear probing: find, get-or-insert, clear.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_func, req_lookup_key
//   rsp      out        rsp_valid / rsp_stall  rsp_hit, rsp_inserted, rsp_slot,
//                                              rsp_status, rsp_occupancy
//   csr      in         csr_valid / csr_ready  csr_max_fill
//
// Find/get: accept, hash, reduction to the home slot, a probe of one slot
// after another, and finish; the probe loop reads one memory entry per cycle.
// Clear empties every slot in a sweep before the finish.
// After reset a sweep empties every slot; requests stall.
// A stalled response holds; the next request is accepted meanwhile.
// ----------------------------------------------------------------------------
module hashed_key_table_linear_probe_core
   import hkt_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [KEY_W-1:0]   req_lookup_key,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic               rsp_inserted,
   output logic [OUT_W-1:0]   rsp_slot,
   output logic               rsp_status,
   output logic [OUT_W-1:0]   rsp_occupancy,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [FILL_W-1:0]  csr_max_fill
);

   hkt_cmd_type    cmd;
   hkt_status_type status;

   assign csr_ready = 1'b1;

   hkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hkt_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg_we         (csr_valid && csr_ready),
      .cfg_data       (csr_max_fill),
      .req_func       (req_func),
      .req_lookup_key (req_lookup_key),
      .cmd            (cmd),
      .status         (status),
      .rsp_hit        (rsp_hit),
      .rsp_inserted   (rsp_inserted),
      .rsp_slot       (rsp_slot),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

`ifndef NO_ASSERTIONS
   a_init_stalls: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request accepted during reset sweep");

   a_insert_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted |-> !rsp_hit && !rsp_status && (rsp_occupancy != '0))
      else $error("insert response with hit, refusal or zero occupancy");

   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_hit && !rsp_inserted && (rsp_slot == '0))
      else $error("refused insert reports a slot");

   a_busy_while_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");
`endif

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear-probe key table core. A predictor keeps
// its own copy of the slot keys, the occupied flags, the entry count and the
// fill limit. It computes the response of every accepted request, and the
// response sink compares each returned response with the oldest one pending.
// Directed tests cover the empty table, wraparound probing, the fill limit
// (zero included), clear and the unused code. Random traffic at light load,
// deep load and tight limits follows, with random idle cycles on both sides
// and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hkt_pkg::*;

   localparam int TABLE_SLOTS = 1024;
   localparam int IDLE_LIMIT = 8000;
   localparam int SHOW_LIMIT = 10;
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   typedef enum {PROBE_MISS, PROBE_HIT, PROBE_EMPTY} probe_result_type;

   typedef struct packed {
      logic             hit;
      logic             inserted;
      logic [OUT_W-1:0] slot;
      logic             status;
      logic [OUT_W-1:0] occupancy;
   } table_rsp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [FUNC_W-1:0]  req_func;
   logic [KEY_W-1:0]   req_lookup_key;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_hit;
   logic               rsp_inserted;
   logic [OUT_W-1:0]   rsp_slot;
   logic               rsp_status;
   logic [OUT_W-1:0]   rsp_occupancy;
   logic               csr_valid;
   logic               csr_ready;
   logic [FILL_W-1:0]  csr_max_fill;

   // predicted table contents
   logic [KEY_W-1:0]   tbl_key [TABLE_SLOTS];
   bit                 tbl_used [TABLE_SLOTS];
   logic [COUNT_W-1:0] tbl_count;
   logic [FILL_W-1:0]  fill_limit;

   table_rsp_type      pending_rsps [$];
   logic [KEY_W-1:0]   key_pool [$];

   int req_gap_max = 12;
   int rsp_gap_max = 12;
   int rsp_hold_left = 0;

   int fail_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int hit_count = 0;
   int insert_count = 0;
   int refused_count = 0;
   int clear_count = 0;
   int peak_occupancy = 0;
   int fill_writes = 0;

   hashed_key_table_linear_probe_core #(
      .SLOTS(TABLE_SLOTS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_lookup_key (req_lookup_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_inserted   (rsp_inserted),
      .rsp_slot       (rsp_slot),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_max_fill   (csr_max_fill)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] mix_key(input logic [31:0] v);
      logic [31:0] x;
      x = v;
      x = (x + MIX_C0) + (x << 12);
      x = (x ^ MIX_C1) ^ (x >> 19);
      x = (x + MIX_C2) + (x << 5);
      x = (x + MIX_C3) ^ (x << 9);
      x = (x + MIX_C4) + (x << 3);
      x = (x ^ MIX_C5) ^ (x >> 16);
      return x;
   endfunction

   function automatic int home_slot(input logic [KEY_W-1:0] k);
      return int'(mix_key({1'b0, k}) % 32'(TABLE_SLOTS));
   endfunction

   // walk from the home slot until the key or a hole turns up
   function automatic probe_result_type search_slot(input logic [KEY_W-1:0] k,
                                                    output int pos);
      int idx;
      int n;
      idx = home_slot(k);
      pos = 0;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (!tbl_used[idx]) begin
            pos = idx;
            return PROBE_EMPTY;
         end
         if (tbl_key[idx] == k) begin
            pos = idx;
            return PROBE_HIT;
         end
         idx = (idx + 1) % TABLE_SLOTS;
      end
      return PROBE_MISS;
   endfunction

   function automatic void empty_table();
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      tbl_count = '0;
   endfunction

   function automatic table_rsp_type predict_table(input logic [FUNC_W-1:0] f,
                                                   input logic [KEY_W-1:0] k);
      table_rsp_type r;
      probe_result_type found;
      int pos;
      r = '0;
      case (f)
         FUNC_FIND: begin
            found = search_slot(k, pos);
            if (found == PROBE_HIT) begin
               r.hit = 1'b1;
               r.slot = OUT_W'(pos);
            end
         end
         FUNC_GET: begin
            found = search_slot(k, pos);
            if (found == PROBE_HIT) begin
               r.hit = 1'b1;
               r.slot = OUT_W'(pos);
            end else if (found == PROBE_EMPTY && tbl_count < fill_limit) begin
               tbl_key[pos] = k;
               tbl_used[pos] = 1'b1;
               tbl_count = tbl_count + 1'b1;
               r.inserted = 1'b1;
               r.slot = OUT_W'(pos);
            end else begin
               r.status = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            empty_table();
            clear_count++;
         end
         default: ;
      endcase
      r.occupancy = tbl_count[OUT_W-1:0];
      hit_count += r.hit;
      insert_count += r.inserted;
      refused_count += r.status;
      if (int'(tbl_count) > peak_occupancy) peak_occupancy = int'(tbl_count);
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_req(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_lookup_key <= k;
      do @(posedge clock); while (!(req_valid && !req_stall));
      pending_rsps.push_back(predict_table(f, k));
      req_count++;
   endtask

   task automatic drain_rsps();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // only written with the table idle
   task automatic write_fill_limit(input logic [FILL_W-1:0] v);
      drain_rsps();
      csr_valid <= 1'b1;
      csr_max_fill <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      fill_limit = v;
      fill_writes++;
   endtask

   function automatic logic [KEY_W-1:0] fresh_key();
      return KEY_W'($urandom);
   endfunction

   function automatic logic [KEY_W-1:0] key_with_home(input int target);
      logic [KEY_W-1:0] k;
      do k = fresh_key(); while (home_slot(k) != target);
      return k;
   endfunction

   // ---------------------------------------------------------------- response sink

   task automatic check_rsp(input table_rsp_type seen);
      table_rsp_type want;
      rsp_count++;
      if (pending_rsps.size() == 0) begin
         fail_count++;
         if (fail_count <= SHOW_LIMIT)
            $display("tb: %0t unexpected response hit=%0d ins=%0d slot=%0d st=%0d occ=%0d",
                     $realtime, seen.hit, seen.inserted, seen.slot, seen.status,
                     seen.occupancy);
         return;
      end
      want = pending_rsps.pop_front();
      if (seen.hit !== want.hit || seen.inserted !== want.inserted ||
          seen.slot !== want.slot || seen.status !== want.status ||
          seen.occupancy !== want.occupancy) begin
         fail_count++;
         if (fail_count <= SHOW_LIMIT) begin
            $display("tb: %0t response %0d mismatch: exp hit=%0d ins=%0d slot=%0d st=%0d occ=%0d",
                     $realtime, rsp_count, want.hit, want.inserted, want.slot,
                     want.status, want.occupancy);
            $display("tb:    got hit=%0d ins=%0d slot=%0d st=%0d occ=%0d",
                     seen.hit, seen.inserted, seen.slot, seen.status,
                     seen.occupancy);
         end
      end
   endtask

   initial begin : rsp_sink
      table_rsp_type seen;
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen.hit = rsp_hit;
            seen.inserted = rsp_inserted;
            seen.slot = rsp_slot;
            seen.status = rsp_status;
            seen.occupancy = rsp_occupancy;
            check_rsp(seen);
            stall_left = $urandom_range(0, rsp_gap_max);
         end
         // a long hold-off overrides the per-response stall
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("tb: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   task automatic test_empty_table();
      send_req(FUNC_FIND, '0);
      send_req(FUNC_NONE, '1);
      send_req(FUNC_GET, '0);
      send_req(FUNC_GET, '0);
      send_req(FUNC_FIND, '0);
      send_req(FUNC_GET, '1);
      send_req(FUNC_FIND, '1);
      send_req(FUNC_FIND, 31'h2a5a_5a5a);
   endtask

   // keys homed on the last slot spill over into slot 0 and beyond
   task automatic test_wraparound();
      logic [KEY_W-1:0] k;
      repeat (3) send_req(FUNC_GET, key_with_home(TABLE_SLOTS - 1));
      k = key_with_home(0);
      send_req(FUNC_GET, k);
      send_req(FUNC_FIND, k);
      send_req(FUNC_FIND, key_with_home(TABLE_SLOTS - 1));
   endtask

   task automatic test_fill_limit();
      logic [KEY_W-1:0] kept;
      logic [KEY_W-1:0] other;
      kept = fresh_key();
      other = fresh_key();
      send_req(FUNC_CLEAR, fresh_key());
      write_fill_limit(10'd3);
      send_req(FUNC_GET, kept);
      send_req(FUNC_GET, other);
      send_req(FUNC_GET, fresh_key());
      send_req(FUNC_GET, fresh_key());
      send_req(FUNC_GET, kept);
      write_fill_limit('0);
      send_req(FUNC_GET, fresh_key());
      send_req(FUNC_GET, other);
      send_req(FUNC_FIND, other);
   endtask

   task automatic test_clear_and_unused();
      write_fill_limit(FILL_RESET);
      send_req(FUNC_CLEAR, '1);
      send_req(FUNC_FIND, key_pool.size() ? key_pool[0] : '0);
      send_req(FUNC_NONE, '0);
   endtask

   // mixed traffic over a pool of keys so that most lookups land on known keys
   task automatic run_table_traffic(input int n, input int pool_cap, input int clear_pm);
      int roll;
      logic [KEY_W-1:0] k;
      logic [FUNC_W-1:0] f;
      for (int i = 0; i < n; i++) begin
         if (i % 128 == 0) begin
            req_gap_max = $urandom_range(0, 2) ? 12 : 0;
            rsp_gap_max = $urandom_range(0, 2) ? 12 : 0;
         end
         roll = $urandom_range(0, 999);
         if (roll < clear_pm) begin
            send_req(FUNC_CLEAR, fresh_key());
         end else if (roll < clear_pm + 20) begin
            send_req(FUNC_NONE, fresh_key());
         end else begin
            if (key_pool.size() == 0 || $urandom_range(0, 9) == 0 ||
                (key_pool.size() < pool_cap && $urandom_range(0, 3) == 0)) begin
               k = fresh_key();
               if (key_pool.size() < pool_cap) key_pool.push_back(k);
            end else begin
               k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end
            f = ($urandom_range(0, 9) < 6) ? FUNC_GET : FUNC_FIND;
            send_req(f, k);
         end
      end
      req_gap_max = 12;
      rsp_gap_max = 12;
   endtask

   // hold responses off long enough for the core to back up into its input
   task automatic test_backpressure();
      drain_rsps();
      req_gap_max = 0;
      rsp_hold_left = 300;
      run_table_traffic(40, 64, 0);
   endtask

   task automatic test_deep_load();
      logic [KEY_W-1:0] k;
      write_fill_limit('1);
      send_req(FUNC_CLEAR, fresh_key());
      key_pool.delete();
      req_gap_max = 0;
      rsp_gap_max = 0;
      repeat (700) begin
         k = fresh_key();
         key_pool.push_back(k);
         send_req(FUNC_GET, k);
      end
      req_gap_max = 12;
      rsp_gap_max = 12;
      run_table_traffic(600, 900, 0);
   endtask

   task automatic test_limit_churn();
      write_fill_limit(10'd16);
      send_req(FUNC_CLEAR, fresh_key());
      key_pool.delete();
      run_table_traffic(300, 40, 20);
      write_fill_limit(10'h155);
      key_pool.delete();
      run_table_traffic(400, 300, 3);
      write_fill_limit(10'h2aa);
      run_table_traffic(100, 300, 0);
   endtask

   initial begin : main_seq
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_FIND;
      req_lookup_key <= '0;
      csr_valid <= 1'b0;
      csr_max_fill <= FILL_RESET;
      empty_table();
      fill_limit = FILL_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_wraparound();
      test_fill_limit();
      test_clear_and_unused();
      test_backpressure();
      test_deep_load();
      test_limit_churn();

      drain_rsps();
      // let any stray response show up
      repeat (40) @(posedge clock);
      fail_count += pending_rsps.size();

      $display("tb: %0d requests, %0d responses: %0d hits, %0d inserts, %0d refused",
               req_count, rsp_count, hit_count, insert_count, refused_count);
      $display("tb: %0d clears, %0d fill limit writes, peak occupancy %0d, %0d failures",
               clear_count, fill_writes, peak_occupancy, fail_count);
      if (fail_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

[hashed_key_table_linear_probe_core.f]
design/hkt_pkg.sv
design/hkt_hash.sv
design/hkt_datapath.sv
design/hkt_ctrl.sv
design/hashed_key_table_linear_probe_core.sv
dv/tb.sv
